### sv/skts_pkg.sv
// skts_pkg: shared constants for the sorted key table search block
// request and status codes, key width and table defaults
// no dependencies
package skts_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int KEY_W = 128;
	localparam int HALF_W = 64;
	localparam int GAP_LIMIT = 9;
	localparam int GAP_MUL = 3;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_SORT = 2'd1;
	localparam logic [1:0] REQ_FIND = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef logic [KEY_W-1:0] key_t;

endpackage

### sv/sorted_key_table_search.sv
// sorted_key_table_search: table of 128-bit keys with append, shellsort and find
// one synchronous key memory walked by a sequencer; depends on skts_pkg
//
// usage: a request transaction (req_valid, req_stall) carries req_type, key_hi and
// key_lo; every request yields exactly one response transaction (rsp_valid,
// rsp_stall) carrying status and entry_index.
// requests are taken one at a time: req_stall is high while a request is being
// worked on or its response cannot yet be moved into the output register.
// a finished response waits in the output register, so the next request is taken
// while the receiver holds rsp_stall high.
// steps, paced by the single registered read port of the key memory:
//   append or unused code: straight to the response register
//   find: binary search probes over the sorted entries, then a scan of the tail
//   sort: the shellsort insertion walk, one compare at a time
// reset clears entry and sorted counts and the response valid flag; the key
// memory is not cleared, since only written entries are ever read.
module sorted_key_table_search
	import skts_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [63:0] key_hi,
	input  logic [63:0] key_lo,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [7:0]  entry_index
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int BW = CW + 1;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_RESP  = 12'b000000000010,
		S_SGAP  = 12'b000000000100,
		S_SPOS  = 12'b000000001000,
		S_SVAL  = 12'b000000010000,
		S_SCMP  = 12'b000000100000,
		S_SNEXT = 12'b000001000000,
		S_GAPDN = 12'b000010000000,
		S_FBIN  = 12'b000100000000,
		S_FCMP  = 12'b001000000000,
		S_FTAIL = 12'b010000000000,
		S_FTCMP = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [CW-1:0] entry_q, sorted_q, srt_q;
	logic [CW-1:0] gap_q, gt_q, pos_q, slot_q, k_q;
	logic [BW-1:0] lo_q, hi_q, mid_q;
	key_t key_q, v_q;
	logic [1:0] res_status_q;
	logic [AW-1:0] res_index_q;
	logic rsp_valid_q;
	logic [1:0] status_q;
	logic [7:0] index_q;

	key_t mem [TABLE_DEPTH];
	key_t rdata_q;
	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	key_t mem_wdata;

	logic [BW:0] mid_sum;
	logic [BW-1:0] mid_c;
	logic [CW+3:0] gap_x9;
	logic [CW+1:0] gt_next;
	logic [CW-1:0] slot_dn;
	logic out_free;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c = mid_sum[BW:1];
	assign gap_x9 = (CW+4)'(gap_q) * (CW+4)'(GAP_LIMIT);
	assign gt_next = (CW+2)'(gt_q) * (CW+2)'(GAP_MUL) + (CW+2)'(1);
	assign slot_dn = slot_q - gap_q;
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign entry_index = index_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = entry_q[AW-1:0];
		mem_wdata = {key_hi, key_lo};
		mem_raddr = pos_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (req_valid && req_type == REQ_APPEND && entry_q < CW'(TABLE_DEPTH))
					mem_we = 1'b1;
			end
			S_SPOS: mem_raddr = pos_q[AW-1:0];
			S_SVAL: begin
				mem_raddr = slot_dn[AW-1:0];
				if (slot_q < gap_q) begin
					mem_we = 1'b1;
					mem_waddr = slot_q[AW-1:0];
					mem_wdata = rdata_q;
				end
			end
			S_SCMP: begin
				mem_we = 1'b1;
				mem_waddr = slot_q[AW-1:0];
				mem_wdata = (rdata_q > v_q) ? rdata_q : v_q;
			end
			S_SNEXT: begin
				mem_raddr = slot_dn[AW-1:0];
				if (slot_q < gap_q) begin
					mem_we = 1'b1;
					mem_waddr = slot_q[AW-1:0];
					mem_wdata = v_q;
				end
			end
			S_FBIN: mem_raddr = AW'(mid_c - BW'(1));
			S_FTAIL: mem_raddr = k_q[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			entry_q <= '0;
			sorted_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_RESP)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						key_q <= {key_hi, key_lo};
						res_status_q <= ST_OK;
						res_index_q <= '0;
						state_q <= S_RESP;
						case (req_type)
							REQ_APPEND: begin
								if (entry_q < CW'(TABLE_DEPTH)) begin
									res_index_q <= entry_q[AW-1:0];
									entry_q <= entry_q + CW'(1);
								end else begin
									res_status_q <= ST_FULL;
								end
							end
							REQ_SORT: begin
								gap_q <= CW'(1);
								state_q <= S_SGAP;
							end
							REQ_FIND: begin
								lo_q <= BW'(1);
								hi_q <= BW'((sorted_q < entry_q) ? sorted_q : entry_q);
								srt_q <= (sorted_q < entry_q) ? sorted_q : entry_q;
								state_q <= S_FBIN;
							end
							default: ;
						endcase
					end
				end
				S_RESP: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						status_q <= res_status_q;
						index_q <= 8'(res_index_q);
						state_q <= S_IDLE;
					end
				end
				S_SGAP: begin
					if (gap_x9 <= (CW+4)'(entry_q)) begin
						gap_q <= CW'(gap_q * CW'(GAP_MUL) + CW'(1));
					end else begin
						pos_q <= gap_q;
						state_q <= S_SPOS;
					end
				end
				S_SPOS: begin
					if (pos_q >= entry_q) begin
						if (gap_q <= CW'(1)) begin
							sorted_q <= entry_q;
							state_q <= S_RESP;
						end else begin
							gt_q <= CW'(1);
							state_q <= S_GAPDN;
						end
					end else begin
						slot_q <= pos_q;
						state_q <= S_SVAL;
					end
				end
				S_SVAL: begin
					v_q <= rdata_q;
					if (slot_q >= gap_q) begin
						state_q <= S_SCMP;
					end else begin
						pos_q <= pos_q + CW'(1);
						state_q <= S_SPOS;
					end
				end
				S_SCMP: begin
					if (rdata_q > v_q) begin
						slot_q <= slot_dn;
						state_q <= S_SNEXT;
					end else begin
						pos_q <= pos_q + CW'(1);
						state_q <= S_SPOS;
					end
				end
				S_SNEXT: begin
					if (slot_q >= gap_q) begin
						state_q <= S_SCMP;
					end else begin
						pos_q <= pos_q + CW'(1);
						state_q <= S_SPOS;
					end
				end
				S_GAPDN: begin
					if (gt_next == (CW+2)'(gap_q)) begin
						gap_q <= gt_q;
						pos_q <= gt_q;
						state_q <= S_SPOS;
					end else begin
						gt_q <= gt_next[CW-1:0];
					end
				end
				S_FBIN: begin
					if (lo_q <= hi_q) begin
						mid_q <= mid_c;
						state_q <= S_FCMP;
					end else begin
						k_q <= srt_q;
						state_q <= S_FTAIL;
					end
				end
				S_FCMP: begin
					if (key_q > rdata_q) begin
						lo_q <= mid_q + BW'(1);
						state_q <= S_FBIN;
					end else if (key_q == rdata_q) begin
						res_index_q <= AW'(mid_q - BW'(1));
						state_q <= S_RESP;
					end else begin
						hi_q <= mid_q - BW'(1);
						state_q <= S_FBIN;
					end
				end
				S_FTAIL: begin
					if (k_q < entry_q) begin
						state_q <= S_FTCMP;
					end else begin
						res_status_q <= ST_NOT_FOUND;
						state_q <= S_RESP;
					end
				end
				S_FTCMP: begin
					if (key_q == rdata_q) begin
						res_index_q <= k_q[AW-1:0];
						state_q <= S_RESP;
					end else begin
						k_q <= k_q + CW'(1);
						state_q <= S_FTAIL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
